>>> hdl/longest_increasing_subsequence_len_defines.svh
// Assertion macros for the longest increasing subsequence RTL.
`ifndef LONGEST_INCREASING_SUBSEQUENCE_LEN_DEFINES_SVH
`define LONGEST_INCREASING_SUBSEQUENCE_LEN_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is low
`define LIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lis assertion failed");
// Next-cycle implication, disabled while reset is low
`define LIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lis assertion failed");
`else
`define LIS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define LIS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

>>> hdl/lis_pkg.sv
// Shared constants, types and helpers of the longest increasing subsequence block.
package lis_pkg;

    localparam int MAX_LEN    = 1024;
    localparam int VALUE_BITS = 32;
    localparam int IDX_W      = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
    localparam int CNT_W      = 11;

    // sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EVAL,
        ST_SEARCH,
        ST_DONE
    } t_state;

    // finished result handed from the sequencer to the output register
    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] len;
        logic             ovf;
        logic             fin;
    } t_res;

    // midpoint of a search window, floor((lo + hi) / 2)
    function automatic logic [IDX_W-1:0] mid_of(input logic [IDX_W-1:0] lo,
                                                input logic [IDX_W-1:0] hi);
        logic [IDX_W:0] s;
        s = {1'b0, lo} + {1'b0, hi};
        return s[IDX_W:1];
    endfunction

endpackage

>>> hdl/lis_ram.sv
// Generic simple dual-port RAM with registered read.
module lis_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/lis_seq.sv
// Sequencer and datapath: tail table update with a one-read-per-step binary search.
`include "longest_increasing_subsequence_len_defines.svh"

module lis_seq
    import lis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last,
    input  logic                  i_take,
    output logic                  o_busy,
    output t_res                  o_res
);

    t_state r_state, n_state;

    logic [VALUE_BITS-1:0] r_v, n_v;
    logic                  r_fin, n_fin;
    logic [CNT_W-1:0]      r_count, n_count;
    logic                  r_ovf, n_ovf;
    logic [VALUE_BITS-1:0] r_first, n_first;
    logic [VALUE_BITS-1:0] r_last, n_last;
    logic [IDX_W-1:0]      r_lo, n_lo;
    logic [IDX_W-1:0]      r_hi, n_hi;
    logic [IDX_W-1:0]      r_mid, n_mid;

    logic                  ram_we;
    logic [IDX_W-1:0]      ram_waddr;
    logic                  ram_re;
    logic [IDX_W-1:0]      ram_raddr;
    logic [VALUE_BITS-1:0] ram_rdata;

    logic [CNT_W-1:0]      cnt_m1;
    logic                  tail_ge;
    logic                  done;

    assign cnt_m1  = r_count - CNT_W'(1);
    // search compare: fetched tail against the incoming word
    assign tail_ge = (ram_rdata >= r_v);
    assign done    = (r_state == ST_DONE) && i_take;

    // tail table
    lis_ram #(
        .WIDTH (VALUE_BITS),
        .DEPTH (MAX_LEN)
    ) u_tails (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_v),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (r_count > CNT_W'(1) && r_v >= r_first && r_v <= r_last) begin
                    n_state = ST_SEARCH;
                end else begin
                    n_state = ST_DONE;
                end
            end
            ST_SEARCH: begin
                if (n_lo == n_hi) n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_v       = r_v;
        n_fin     = r_fin;
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_first   = r_first;
        n_last    = r_last;
        n_lo      = r_lo;
        n_hi      = r_hi;
        n_mid     = r_mid;
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_v   = i_value;
                    n_fin = i_last;
                end
            end
            ST_EVAL: begin
                if (r_count == '0) begin
                    // first word of a sequence
                    ram_we    = 1'b1;
                    n_first   = r_v;
                    n_last    = r_v;
                    n_count   = CNT_W'(1);
                end else if (r_v < r_first) begin
                    ram_we    = 1'b1;
                    n_first   = r_v;
                    if (r_count == CNT_W'(1)) n_last = r_v;
                end else if (r_v > r_last) begin
                    if (r_count < CNT_W'(MAX_LEN)) begin
                        ram_we    = 1'b1;
                        ram_waddr = r_count[IDX_W-1:0];
                        n_last    = r_v;
                        n_count   = r_count + CNT_W'(1);
                    end else begin
                        n_ovf = 1'b1;
                    end
                end else if (r_count > CNT_W'(1)) begin
                    // open the search window over all tails
                    n_lo      = '0;
                    n_hi      = cnt_m1[IDX_W-1:0];
                    n_mid     = mid_of('0, cnt_m1[IDX_W-1:0]);
                    ram_re    = 1'b1;
                    ram_raddr = n_mid;
                end
            end
            ST_SEARCH: begin
                // one halving step per cycle, next read issued at once
                if (tail_ge) begin
                    n_hi = r_mid;
                end else begin
                    n_lo = r_mid + IDX_W'(1);
                end
                if (n_lo == n_hi) begin
                    ram_we    = 1'b1;
                    ram_waddr = n_lo;
                    if (n_lo == '0) n_first = r_v;
                    if (n_lo == cnt_m1[IDX_W-1:0]) n_last = r_v;
                end else begin
                    n_mid     = mid_of(n_lo, n_hi);
                    ram_re    = 1'b1;
                    ram_raddr = n_mid;
                end
            end
            ST_DONE: begin
                if (i_take && r_fin) begin
                    n_count = '0;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_ovf   <= n_ovf;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_v     <= n_v;
        r_fin   <= n_fin;
        r_first <= n_first;
        r_last  <= n_last;
        r_lo    <= n_lo;
        r_hi    <= n_hi;
        r_mid   <= n_mid;
    end

    assign o_busy      = (r_state != ST_IDLE);
    assign o_res.valid = (r_state == ST_DONE);
    assign o_res.len   = r_count;
    assign o_res.ovf   = r_ovf;
    assign o_res.fin   = r_fin;

    // checks
    `LIS_ASSERT_IMP(a_window_open, i_clk, i_rst_n, r_state == ST_SEARCH, r_lo < r_hi)
    `LIS_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_LEN))
    `LIS_ASSERT_IMP(a_write_busy, i_clk, i_rst_n, ram_we,
                    r_state == ST_EVAL || r_state == ST_SEARCH)
    `LIS_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, done && r_fin,
                    r_count == '0 && !r_ovf)

endmodule

>>> hdl/longest_increasing_subsequence_len.sv
// Longest strictly increasing subsequence length, streaming, with output register.
//
// Input channel: i_in_valid / o_in_stall carries one word (i_value, i_last).
// Output channel: o_out_valid / i_out_stall carries one word per input word
// (o_run_length, o_overflow, o_is_final). A word moves on a rising edge with
// valid high and stall low.
// One input word is worked on at a time; o_in_stall is high until its result
// has been loaded into the output register. A result goes from the evaluate
// state through s binary search steps and the done state into the output
// register; the next word is taken once the sequencer is back in idle. s is
// zero when no inner tail is replaced (new sequence, new first tail, append,
// dropped append, single tail), else up to ceil(log2(n)) for n tails, 10 with
// 1024 tails. The search does one tail memory read and compare per cycle.
// A waiting result does not block the next input word; that word's result is
// held inside until the output register frees up.
// i_last ends a sequence: after its result the length and overflow clear.
// Reset (synchronous, active low) clears the sequencer, length, overflow and
// output valid; the tail memory needs no clearing pass.
module longest_increasing_subsequence_len
    import lis_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [VALUE_BITS-1:0] i_value,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [CNT_W-1:0]      o_run_length,
    output logic                  o_overflow,
    output logic                  o_is_final
);

    logic             busy;
    logic             take;
    t_res             res;
    logic             r_out_valid;
    logic [CNT_W-1:0] r_len;
    logic             r_ovf;
    logic             r_fin;

    // output register free or draining this cycle
    assign take = !r_out_valid || !i_out_stall;

    lis_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_in_valid && !busy),
        .i_value (i_value),
        .i_last  (i_last),
        .i_take  (take),
        .o_busy  (busy),
        .o_res   (res)
    );

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (take) begin
            r_out_valid <= res.valid;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (take && res.valid) begin
            r_len <= res.len;
            r_ovf <= res.ovf;
            r_fin <= res.fin;
        end
    end

    assign o_in_stall   = busy;
    assign o_out_valid  = r_out_valid;
    assign o_run_length = r_len;
    assign o_overflow   = r_ovf;
    assign o_is_final   = r_fin;

endmodule

>>> sim/longest_increasing_subsequence_len_test.sv
// Self-checking bench for the streaming longest increasing subsequence length block.
`timescale 1ns / 100ps

module longest_increasing_subsequence_len_test;
    import lis_pkg::*;

    localparam int STIM_WORDS   = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 30;
    localparam int N_DIRECTED   = 20;

    // one expected output word
    typedef struct packed {
        logic [CNT_W-1:0] len;
        logic             ovf;
        logic             fin;
    } t_lis_word;

    // one directed stimulus row; typed rows carry their own expected length
    typedef struct {
        logic [VALUE_BITS-1:0] value;
        logic                  last;
        bit                    typed;
        logic [CNT_W-1:0]      len;
        logic                  ovf;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic [VALUE_BITS-1:0] i_value;
    logic                  i_last;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic [CNT_W-1:0]      o_run_length;
    logic                  o_overflow;
    logic                  o_is_final;

    longest_increasing_subsequence_len dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_value      (i_value),
        .i_last       (i_last),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_run_length (o_run_length),
        .o_overflow   (o_overflow),
        .o_is_final   (o_is_final)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: smallest tail per run length, current length, sticky overflow
    logic [VALUE_BITS-1:0] tail_table [MAX_LEN];
    int                    seq_len = 0;
    logic                  seq_ovf = 1'b0;

    t_lis_word awaited_words [$];
    int        words_sent    = 0;
    int        words_checked = 0;
    int        mismatches    = 0;
    int        burst_left    = 0;
    int        idle_cycles   = 0;

    t_stim_row directed_rows [N_DIRECTED] = '{
        '{32'h0000_0000, 1'b0, 1'b1, 11'd1, 1'b0},  // first value of a sequence
        '{32'h0000_0000, 1'b0, 1'b1, 11'd1, 1'b0},  // duplicate of the first tail
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},  // largest value appends
        '{32'hFFFF_FFFF, 1'b0, 1'b1, 11'd2, 1'b0},  // duplicate of the last tail
        '{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},  // lowers the last tail
        '{32'h0000_0007, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0006, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0000, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h0000_0005, 1'b0, 1'b0, 11'd0, 1'b0},  // duplicate of an inner tail
        '{32'h0000_0008, 1'b1, 1'b0, 11'd0, 1'b0},  // closes the sequence
        '{32'h8000_0000, 1'b1, 1'b1, 11'd1, 1'b0},  // one-word sequence
        '{32'h0000_0064, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0032, 1'b0, 1'b1, 11'd1, 1'b0},  // below the first tail
        '{32'h0000_0031, 1'b0, 1'b1, 11'd1, 1'b0},
        '{32'h0000_0033, 1'b0, 1'b1, 11'd2, 1'b0},
        '{32'h0000_0032, 1'b1, 1'b1, 11'd2, 1'b0},
        '{32'h5555_5555, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'hAAAA_AAAA, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 11'd0, 1'b0},
        '{32'hFFFF_FFFE, 1'b1, 1'b0, 11'd0, 1'b0}
    };

    // patience step: update the tail table with one value, return the output word
    function automatic t_lis_word patience_step(input logic [VALUE_BITS-1:0] v,
                                                input logic fin);
        t_lis_word w;
        int        lo;
        int        hi;
        int        mid;
        if (seq_len == 0) begin
            tail_table[0] = v;
            seq_len = 1;
        end else if (v < tail_table[0]) begin
            tail_table[0] = v;
        end else if (v > tail_table[seq_len-1]) begin
            if (seq_len < MAX_LEN) begin
                tail_table[seq_len] = v;
                seq_len++;
            end else begin
                seq_ovf = 1'b1;
            end
        end else begin
            // first tail not below v
            lo = 0;
            hi = seq_len - 1;
            while (lo < hi) begin
                mid = (lo + hi) / 2;
                if (tail_table[mid] >= v) hi = mid;
                else lo = mid + 1;
            end
            tail_table[lo] = v;
        end
        w.len = seq_len[CNT_W-1:0];
        w.ovf = seq_ovf;
        w.fin = fin;
        if (fin) begin
            seq_len = 0;
            seq_ovf = 1'b0;
        end
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH word %0d %s: got %0d want %0d", words_checked, what, got, want);
        mismatches++;
    endtask

    // offer one word, wait for acceptance, log its expectation, then maybe pause
    task automatic send_word(input logic [VALUE_BITS-1:0] v, input logic l,
                             input bit typed, input t_lis_word typed_word);
        t_lis_word want;
        int        gap;
        i_in_valid <= 1'b1;
        i_value    <= v;
        i_last     <= l;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = patience_step(v, l);
        if (typed) begin
            want     = typed_word;
            want.fin = l;
        end
        awaited_words.push_back(want);
        words_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // random sequence with values in [0, hi_val]
    task automatic send_random_seq(input int n, input logic [VALUE_BITS-1:0] hi_val);
        for (int k = 0; k < n; k++)
            send_word($urandom_range(0, hi_val), k == n - 1, 1'b0, '0);
    endtask

    // rising ramp with scattered lower values; long ones fill the table
    task automatic send_ramp(input int n, input int unsigned step, input bit top_out);
        logic [63:0] v;
        for (int k = 0; k < n; k++) begin
            v = 64'(k) * step + $urandom_range(0, step - 1);
            send_word(v[VALUE_BITS-1:0], 1'b0, 1'b0, '0);
            if ($urandom_range(0, 9) == 0)
                send_word($urandom_range(0, v[VALUE_BITS-1:0]), 1'b0, 1'b0, '0);
        end
        if (top_out) repeat (3) send_word(32'hFFFF_FFFF, 1'b0, 1'b0, '0);
        send_word($urandom, 1'b1, 1'b0, '0);
    endtask

    // stimulus
    initial begin
        t_lis_word typed_word;
        bit        long_run_done;
        int        kind;
        long_run_done = 1'b0;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_value    <= '0;
        i_last     <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < N_DIRECTED; r++) begin
            typed_word.len = directed_rows[r].len;
            typed_word.ovf = directed_rows[r].ovf;
            typed_word.fin = directed_rows[r].last;
            send_word(directed_rows[r].value, directed_rows[r].last,
                      directed_rows[r].typed, typed_word);
        end

        while (words_sent < STIM_WORDS) begin
            if (!long_run_done && words_sent >= 400) begin
                // long enough to fill the table and overflow it
                send_ramp(1060, 32'd3_000_000, 1'b1);
                long_run_done = 1'b1;
            end else begin
                kind = $urandom_range(0, 9);
                case (kind)
                    0, 1:    send_random_seq($urandom_range(1, 30), 32'd3);
                    2, 3:    send_random_seq($urandom_range(1, 30), 32'd15);
                    4:       send_random_seq($urandom_range(1, 30), 32'd255);
                    5, 6:    send_random_seq($urandom_range(1, 20), 32'hFFFF_FFFF);
                    7, 8:    send_ramp($urandom_range(20, 200),
                                       $urandom_range(1, 20_000_000), $urandom_range(0, 1));
                    default: repeat ($urandom_range(1, 6))
                                 send_word($urandom, $urandom_range(0, 1), 1'b0, '0);
                endcase
            end
        end
        i_in_valid <= 1'b0;

        while (awaited_words.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && awaited_words.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // receiver stall pattern, with a long hold-off now and then
    initial begin
        int mode;
        int holdoff_at;
        holdoff_at = 150;
        i_out_stall <= 1'b0;
        @(posedge i_clk);
        forever begin
            mode = $urandom_range(0, 2);
            repeat ($urandom_range(5, 60)) begin
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= $urandom_range(0, 1);
                    default: i_out_stall <= ($urandom_range(0, 3) != 0);
                endcase
                @(posedge i_clk);
            end
            if (words_checked >= holdoff_at) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                holdoff_at += 800;
            end
        end
    end

    // output check against the oldest expectation
    always @(posedge i_clk) begin
        t_lis_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (awaited_words.size() == 0) begin
                report_mismatch("unexpected word, run_length", o_run_length, 0);
            end else begin
                want = awaited_words.pop_front();
                if (o_run_length !== want.len)
                    report_mismatch("run_length", o_run_length, want.len);
                if (o_overflow !== want.ovf)
                    report_mismatch("overflow", o_overflow, want.ovf);
                if (o_is_final !== want.fin)
                    report_mismatch("is_final", o_is_final, want.fin);
            end
            words_checked++;
        end
    end

    // watchdog: too long without a word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles == IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

endmodule
